### src/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] START_SLACK = 32'd2;

    typedef enum logic [2:0] {
        EV_ADDED    = 3'd0,
        EV_REPLACED = 3'd1,
        EV_PAST     = 3'd2,
        EV_FULL     = 3'd3,
        EV_FIRED    = 3'd4,
        EV_IDLE     = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0]  key;
        logic [31:0] due;
        logic [31:0] period;
        logic        repeats;
    } entry_t;

    typedef struct packed {
        logic   acc_add;
        logic   acc_tick;
        logic   scan_start;
        logic   scan_pick;
        logic   load_repeat;
        logic   fire;
        logic   write;
        logic   emit;
        event_t emit_ev;
        logic   emit_last;
    } cmd_t;

    typedef struct packed {
        logic   add_past;
        logic   scan_last;
        logic   found;
        logic   more;
        logic   resched;
        logic   report_ok;
        logic   fire_last;
        logic   none_reported;
        logic   out_free;
        event_t store_ev;
    } status_t;

endpackage

### src/periodic_task_timer_table.sv
`timescale 1ns / 1ps

// Periodic task timer table: a seconds counter and a table of TABLE_DEPTH timed
// tasks held in a memory with a valid bit per entry. Every table lookup is a
// sequential pass over the memory, one entry per cycle with a registered read.
// An add makes one pass to find a matching entry or a free slot and writes
// the task there if it finds one; when its start time is already behind the
// counter it makes no pass and only reports that. A tick with nothing due
// makes one pass and then reports that it is idle. In a tick that fires
// entries, each fired entry costs one pass to find it and each reschedule one
// more pass to store it. Results go out through an output register; a result
// that is ready waits while that register is still full. The next item is
// taken once the current one has finished its work and placed its last
// result in the register.

module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  task_id,
    input  logic [31:0] start_time,
    input  logic [31:0] interval,
    input  logic        repeat_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  fired_id,
    output logic [31:0] due_time,
    output logic        last
);

    cmd_t    cmd;
    status_t status;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    ptt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .task_id    (task_id),
        .start_time (start_time),
        .interval   (interval),
        .repeat_req (repeat_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .fired_id   (fired_id),
        .due_time   (due_time),
        .last       (last)
    );

endmodule

### src/ptt_ctrl.sv
`timescale 1ns / 1ps

module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    kind,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PICK  = 3'd1;
    localparam logic [2:0] S_FIRE  = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_PAST  = 3'd5;
    localparam logic [2:0] S_NONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_tick_reg;
    logic       is_tick_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        is_tick_next = is_tick_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    is_tick_next = ~kind;
                    if (kind)
                    begin
                        cmd.acc_add = 1'b1;
                        if (status.add_past)
                        begin
                            state_next = S_PAST;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_STORE;
                        end
                    end
                    else
                    begin
                        cmd.acc_tick   = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_pick  = 1'b1;
                        state_next     = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                if (status.scan_last)
                begin
                    state_next = S_FIRE;
                end
            end
            S_STORE:
            begin
                if (status.scan_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_FIRE:
            begin
                if (!status.found)
                begin
                    state_next = status.none_reported ? S_NONE : S_IDLE;
                end
                else if (!status.report_ok || status.out_free)
                begin
                    cmd.fire      = 1'b1;
                    cmd.emit      = status.report_ok;
                    cmd.emit_ev   = EV_FIRED;
                    cmd.emit_last = status.fire_last;
                    if (status.resched)
                    begin
                        cmd.load_repeat = 1'b1;
                        cmd.scan_start  = 1'b1;
                        state_next      = S_STORE;
                    end
                    else if (status.more)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_pick  = 1'b1;
                        state_next     = S_PICK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRITE:
            begin
                if (is_tick_reg)
                begin
                    cmd.write = 1'b1;
                    if (status.more)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_pick  = 1'b1;
                        state_next     = S_PICK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.write     = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = status.store_ev;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = EV_PAST;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_NONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = EV_IDLE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            is_tick_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_tick_reg <= is_tick_next;
        end
    end

endmodule

### src/ptt_dp.sv
`timescale 1ns / 1ps

module ptt_dp
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [7:0]  task_id,
    input  logic [31:0] start_time,
    input  logic [31:0] interval,
    input  logic        repeat_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  fired_id,
    output logic [31:0] due_time,
    output logic        last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;

    logic [31:0]            now_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [IDX_W-1:0] issue_idx_reg;
    logic             issuing_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             eval_vld_reg;
    logic             scan_pick_reg;

    logic             found_reg;
    logic             more_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [7:0]       best_key_reg;
    logic [31:0]      best_per_reg;
    logic             best_rep_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic [7:0]  cand_key_reg;
    logic [31:0] cand_due_reg;
    logic [31:0] cand_per_reg;
    logic        cand_rep_reg;

    logic [CNT_W-1:0] fire_cnt_reg;

    logic        out_valid_reg;
    event_t      event_res_reg;
    logic [7:0]  fired_id_reg;
    logic [31:0] due_time_reg;
    logic        last_reg;

    logic [31:0]      due_add;
    logic             eval_valid;
    logic             hit_pick;
    logic             take_pick;
    logic             hit_match;
    logic             hit_free;
    logic             slot_ok;
    logic [IDX_W-1:0] slot;
    entry_t           cand_entry;

    assign due_add = (start_time != 32'd0) ? start_time + interval
                                           : now_reg + interval + START_SLACK;

    assign eval_valid = valid_reg[eval_idx_reg];
    assign hit_pick   = eval_vld_reg && scan_pick_reg && eval_valid
                        && (rd_reg.due == now_reg);
    assign take_pick  = hit_pick && (!found_reg || (rd_reg.key < best_key_reg));
    assign hit_match  = eval_vld_reg && !scan_pick_reg && eval_valid && !match_found_reg
                        && (rd_reg.due == cand_due_reg) && (rd_reg.key == cand_key_reg);
    assign hit_free   = eval_vld_reg && !scan_pick_reg && !eval_valid && !free_found_reg;

    assign slot_ok = match_found_reg || free_found_reg;
    assign slot    = match_found_reg ? match_idx_reg : free_idx_reg;

    assign cand_entry.key     = cand_key_reg;
    assign cand_entry.due     = cand_due_reg;
    assign cand_entry.period  = cand_per_reg;
    assign cand_entry.repeats = cand_rep_reg;

    assign status.add_past      = (start_time != 32'd0) && (now_reg > start_time);
    assign status.scan_last     = eval_vld_reg && (eval_idx_reg == LAST_IDX);
    assign status.found         = found_reg;
    assign status.more          = more_reg;
    assign status.resched       = best_rep_reg && (best_per_reg != 32'd0);
    assign status.report_ok     = fire_cnt_reg < CNT_W'(MAX_RESULTS);
    assign status.fire_last     = !more_reg || (fire_cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign status.none_reported = (fire_cnt_reg == '0);
    assign status.out_free      = !out_valid_reg || out_ready;
    assign status.store_ev      = match_found_reg ? EV_REPLACED
                                : (free_found_reg ? EV_ADDED : EV_FULL);

    always_ff @(posedge clk)
    begin
        if (cmd.write && slot_ok)
        begin
            mem[slot] <= cand_entry;
        end
        rd_reg <= mem[issue_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= '0;
            valid_reg       <= '0;
            issuing_reg     <= 1'b0;
            issue_idx_reg   <= '0;
            eval_vld_reg    <= 1'b0;
            scan_pick_reg   <= 1'b0;
            found_reg       <= 1'b0;
            more_reg        <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            fire_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.acc_tick)
            begin
                now_reg <= now_reg + 32'd1;
            end

            if (cmd.fire)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            else if (cmd.write && slot_ok)
            begin
                valid_reg[slot] <= 1'b1;
            end

            if (cmd.scan_start)
            begin
                issuing_reg   <= 1'b1;
                issue_idx_reg <= '0;
                scan_pick_reg <= cmd.scan_pick;
            end
            else if (issuing_reg)
            begin
                if (issue_idx_reg == LAST_IDX)
                begin
                    issuing_reg <= 1'b0;
                end
                else
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
            end
            eval_vld_reg <= issuing_reg;

            if (cmd.scan_start && cmd.scan_pick)
            begin
                found_reg <= 1'b0;
                more_reg  <= 1'b0;
            end
            else if (hit_pick)
            begin
                found_reg <= 1'b1;
                if (found_reg)
                begin
                    more_reg <= 1'b1;
                end
            end

            if (cmd.scan_start && !cmd.scan_pick)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else
            begin
                if (hit_match)
                begin
                    match_found_reg <= 1'b1;
                end
                if (hit_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (cmd.acc_tick)
            begin
                fire_cnt_reg <= '0;
            end
            else if (cmd.fire && status.report_ok)
            begin
                fire_cnt_reg <= fire_cnt_reg + 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= issue_idx_reg;

        if (take_pick)
        begin
            best_idx_reg <= eval_idx_reg;
            best_key_reg <= rd_reg.key;
            best_per_reg <= rd_reg.period;
            best_rep_reg <= rd_reg.repeats;
        end
        if (hit_match)
        begin
            match_idx_reg <= eval_idx_reg;
        end
        if (hit_free)
        begin
            free_idx_reg <= eval_idx_reg;
        end

        if (cmd.acc_add)
        begin
            cand_key_reg <= task_id;
            cand_due_reg <= due_add;
            cand_per_reg <= interval;
            cand_rep_reg <= repeat_req;
        end
        else if (cmd.load_repeat)
        begin
            cand_key_reg <= best_key_reg;
            cand_due_reg <= now_reg + best_per_reg;
            cand_per_reg <= best_per_reg;
            cand_rep_reg <= 1'b1;
        end

        if (cmd.emit)
        begin
            event_res_reg <= cmd.emit_ev;
            last_reg      <= cmd.emit_last;
            unique case (cmd.emit_ev)
                EV_FIRED:
                begin
                    fired_id_reg <= best_key_reg;
                    due_time_reg <= now_reg;
                end
                EV_IDLE:
                begin
                    fired_id_reg <= 8'd0;
                    due_time_reg <= now_reg;
                end
                EV_PAST:
                begin
                    fired_id_reg <= cand_key_reg;
                    due_time_reg <= 32'd0;
                end
                default:
                begin
                    fired_id_reg <= cand_key_reg;
                    due_time_reg <= cand_due_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_res_reg;
    assign fired_id  = fired_id_reg;
    assign due_time  = due_time_reg;
    assign last      = last_reg;

endmodule
